// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RBDR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define RBDR_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- src/rbdr_pkg.sv -----
`default_nettype none

package rbdr_pkg;

  localparam int CELLS     = 256;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int CIDX_W    = CELL_AW + 1;
  localparam int MAX_RUN   = 64;

  // gray = floor((0.35 R + 0.55 G + 0.10 B) / 26), scaled by 100
  localparam int W_RED     = 35;
  localparam int W_GREEN   = 55;
  localparam int W_BLUE    = 10;
  localparam int GRAY_DIV  = 2600;
  localparam int MAX_LEVEL = 9;
  localparam int WSUM_W    = 15;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_SPACE = 8'd32;
  localparam logic [7:0] NEWLINE     = 8'd10;

  localparam int          CFG_IW           = 2;
  localparam logic [CFG_IW-1:0] REG_SCALE_FACTOR = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_RUN_CODE     = CFG_IW'(1);
  localparam logic [3:0]  SCALE_RESET      = 4'd3;
  localparam logic [3:0]  SCALE_MAX        = 4'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_CELL,
    S_UPD
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] len;
    logic [3:0] lev;
  } chunk_t;

  // words one pixel causes: at most one chunk from coding the cell,
  // one from flushing the open run at line end, then a newline
  typedef struct packed {
    chunk_t x;
    chunk_t y;
    logic   nl;
  } enc_req_t;

  function automatic logic [3:0] clamp_factor(input logic [3:0] f);
    logic [3:0] r;
    r = f;
    if (f == 4'd0) r = 4'd1;
    if (f > SCALE_MAX) r = SCALE_MAX;
    return r;
  endfunction

  // floor(sum / f) saturated at MAX_LEVEL, by compares against k*f
  function automatic logic [3:0] div_sat(input logic [6:0] sum, input logic [3:0] f);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= MAX_LEVEL; k++) begin
      if (8'(k) * {4'd0, f} <= {1'b0, sum}) q = 4'(k);
    end
    return q;
  endfunction

  function automatic logic [3:0] gray_level(input logic [WSUM_W-1:0] v);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= MAX_LEVEL; k++) begin
      if (v >= WSUM_W'(k * GRAY_DIV)) q = 4'(k);
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ----- src/rbdr_cell_ram.sv -----
`default_nettype none

module rbdr_cell_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [rbdr_pkg::CELL_AW-1:0] waddr,
  input  wire logic [6:0]                 wdata,
  input  wire logic                       re,
  input  wire logic [rbdr_pkg::CELL_AW-1:0] raddr,
  output logic      [6:0]                 rdata
);

  logic [6:0] mem [rbdr_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/rbdr_encoder.sv -----
`default_nettype none
`include "assert_macros.svh"

module rbdr_encoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire rbdr_pkg::enc_req_t req,
  input  wire logic [7:0]         code_byte,
  input  wire logic               out_stall,
  output logic                    busy,
  output logic                    out_valid,
  output logic [7:0]              out_byte,
  output logic                    last_byte
);

  localparam logic [1:0] BYTE_CODE  = 2'd0;
  localparam logic [1:0] BYTE_COUNT = 2'd1;
  localparam logic [1:0] BYTE_LEVEL = 2'd2;

  rbdr_pkg::enc_req_t pend;
  logic [1:0]         bidx;
  rbdr_pkg::chunk_t   cur;
  logic               use_x;
  logic               on_chunk;
  logic               is_last;
  logic               load;
  logic [7:0]         cur_byte;

  always_comb begin
    use_x    = pend.x.valid;
    on_chunk = pend.x.valid || pend.y.valid;
    cur      = use_x ? pend.x : pend.y;
    load     = busy && (!out_valid || !out_stall);
    if (!on_chunk) begin
      is_last = 1'b1;
    end else if (use_x) begin
      is_last = (bidx == BYTE_LEVEL) && !pend.y.valid && !pend.nl;
    end else begin
      is_last = (bidx == BYTE_LEVEL) && !pend.nl;
    end
    cur_byte = rbdr_pkg::NEWLINE;
    if (on_chunk) begin
      case (bidx)
        BYTE_CODE:  cur_byte = code_byte;
        BYTE_COUNT: cur_byte = {1'b0, cur.len} + rbdr_pkg::ASCII_SPACE;
        BYTE_LEVEL: cur_byte = {4'd0, cur.lev} + rbdr_pkg::ASCII_ZERO;
        default:    cur_byte = rbdr_pkg::NEWLINE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      out_valid    <= 1'b0;
      bidx         <= BYTE_CODE;
      pend.x.valid <= 1'b0;
      pend.y.valid <= 1'b0;
      pend.nl      <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        pend <= req;
        bidx <= BYTE_CODE;
      end else if (load) begin
        if (!on_chunk) begin
          pend.nl <= 1'b0;
          busy    <= 1'b0;
        end else if (bidx == BYTE_LEVEL) begin
          bidx <= BYTE_CODE;
          if (use_x) begin
            pend.x.valid <= 1'b0;
          end else begin
            pend.y.valid <= 1'b0;
          end
          if (is_last) begin
            busy <= 1'b0;
          end
        end else begin
          bidx <= bidx + 2'd1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word register, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= cur_byte;
      last_byte <= is_last;
    end
  end

  `RBDR_NEVER(a_start_while_busy, clk, rst, start && busy, "encoder started while busy")
  `RBDR_NEVER(a_busy_empty, clk, rst, busy && !pend.x.valid && !pend.y.valid && !pend.nl,
              "encoder busy with nothing pending")
  `RBDR_ASSERT(a_last_frees, clk, rst, (load && is_last) |=> !busy,
               "encoder still busy after last word")

endmodule

`default_nettype wire

// ----- src/rgb_block_downscale_rle_top.sv -----
// RGB raster to run-length coded ten-level gray, box-filter downscaled.
// Input channel: in_valid/in_stall with red, green, blue, line_end; a pixel
// is taken when in_valid is high and in_stall low. Output channel:
// out_valid/out_stall with out_byte and last_byte, one word per byte of the
// coded stream; last_byte flags the final word a pixel caused. Pixels that
// finish no cell and end no line give no words.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index 0 writes
// scale_factor, 1 writes run_code_byte; other indexes are ignored.
// Sequence: each pixel walks accept, gray sum, cell read, cell update, one state
// each, an order set by the read-modify-write of the cell store (read in
// S_CELL, written in S_UPD). A pixel that emits words holds off the next
// pixel until they have all loaded into the output register; its first word
// loads once the cell update has started the coder.
// Reset clears counters, the open run and the registers to defaults; the
// cell store is not cleared and needs no clearing pass.
// When out_stall is high the output word holds, byte generation pauses, and
// in_stall rises once the coder is busy.
`default_nettype none
`include "assert_macros.svh"

module rgb_block_downscale_rle_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    red,
  input  wire logic [7:0]                    green,
  input  wire logic [7:0]                    blue,
  input  wire logic                          line_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_byte,
  output logic                               last_byte,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rbdr_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [7:0]                    cfg_data
);

  rbdr_pkg::state_t state, state_next;

  logic [3:0] scale_factor;
  logic [7:0] run_code_byte;

  logic [3:0]                  fac;
  logic [rbdr_pkg::WSUM_W-1:0] wsum;
  logic                        eol;
  logic [6:0]                  gs_new;
  logic [3:0]                  h_val;
  logic                        cell_go;

  logic [2:0]                  line_in_group;
  logic [2:0]                  pixel_in_group;
  logic [6:0]                  group_sum;
  logic [rbdr_pkg::CIDX_W-1:0] cell_index;
  logic [3:0]                  run_level;
  logic [6:0]                  run_length;

  logic       accept;
  logic       last_line;
  logic       group_done;
  logic       in_range;
  logic       mem_re;
  logic       mem_we;
  logic [6:0] mem_rdata;
  logic [6:0] cell_sum;
  logic [3:0] level;
  logic [6:0] rl_next;
  logic [3:0] rv_next;

  rbdr_pkg::enc_req_t req;
  logic               enc_start;
  logic               enc_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= rbdr_pkg::SCALE_RESET;
      run_code_byte <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbdr_pkg::REG_SCALE_FACTOR: scale_factor  <= cfg_data[3:0];
        rbdr_pkg::REG_RUN_CODE:     run_code_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbdr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      rbdr_pkg::S_IDLE: begin
        in_stall = enc_busy;
        if (in_valid && !enc_busy) state_next = rbdr_pkg::S_SUM;
      end
      rbdr_pkg::S_SUM:  state_next = rbdr_pkg::S_CELL;
      rbdr_pkg::S_CELL: state_next = rbdr_pkg::S_UPD;
      rbdr_pkg::S_UPD:  state_next = rbdr_pkg::S_IDLE;
      default:          state_next = rbdr_pkg::S_IDLE;
    endcase
  end

  assign accept     = in_valid && !in_stall;
  assign last_line  = ({1'b0, line_in_group} + 4'd1) >= fac;
  assign group_done = ({1'b0, pixel_in_group} + 4'd1) >= fac;
  assign in_range   = cell_index < rbdr_pkg::CIDX_W'(rbdr_pkg::CELLS);
  assign mem_re     = (state == rbdr_pkg::S_CELL) && group_done && in_range;
  assign mem_we     = (state == rbdr_pkg::S_UPD) && cell_go;

  // reads happen in S_CELL, writes in S_UPD: the sequence keeps them apart
  rbdr_cell_ram u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cell_index[rbdr_pkg::CELL_AW-1:0]),
    .wdata (cell_sum),
    .re    (mem_re),
    .raddr (cell_index[rbdr_pkg::CELL_AW-1:0]),
    .rdata (mem_rdata)
  );

  // ---- cell update and run coding ----
  always_comb begin
    cell_sum = (line_in_group == 3'd0) ? {3'd0, h_val} : mem_rdata + {3'd0, h_val};
    level    = rbdr_pkg::div_sat(cell_sum, fac);
    rl_next  = run_length;
    rv_next  = run_level;
    req      = '0;
    if (cell_go && last_line) begin
      if (rl_next != 7'd0 && level == rv_next) begin
        rl_next = rl_next + 7'd1;
      end else begin
        if (rl_next != 7'd0) begin
          req.x = '{valid: 1'b1, len: rl_next, lev: rv_next};
        end
        rv_next = level;
        rl_next = 7'd1;
      end
      if (rl_next >= 7'(rbdr_pkg::MAX_RUN)) begin
        req.x   = '{valid: 1'b1, len: rl_next, lev: rv_next};
        rl_next = 7'd0;
      end
    end
    if (eol && last_line) begin
      if (rl_next != 7'd0) begin
        req.y   = '{valid: 1'b1, len: rl_next, lev: rv_next};
        rl_next = 7'd0;
      end
      req.nl = 1'b1;
    end
    enc_start = (state == rbdr_pkg::S_UPD) && (req.x.valid || req.y.valid || req.nl);
  end

  // pixel word registers
  always_ff @(posedge clk) begin
    if (accept) begin
      wsum <= rbdr_pkg::WSUM_W'(rbdr_pkg::W_RED) * {7'd0, red}
            + rbdr_pkg::WSUM_W'(rbdr_pkg::W_GREEN) * {7'd0, green}
            + rbdr_pkg::WSUM_W'(rbdr_pkg::W_BLUE) * {7'd0, blue};
      eol  <= line_end;
      fac  <= rbdr_pkg::clamp_factor(scale_factor);
    end
    if (state == rbdr_pkg::S_SUM) begin
      gs_new <= group_sum + {3'd0, rbdr_pkg::gray_level(wsum)};
    end
    if (state == rbdr_pkg::S_CELL) begin
      h_val <= rbdr_pkg::div_sat(gs_new, fac);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_in_group  <= 3'd0;
      pixel_in_group <= 3'd0;
      group_sum      <= 7'd0;
      cell_index     <= '0;
      run_level      <= 4'd0;
      run_length     <= 7'd0;
      cell_go        <= 1'b0;
    end else begin
      case (state)
        rbdr_pkg::S_CELL: begin
          if (group_done) begin
            group_sum      <= 7'd0;
            pixel_in_group <= 3'd0;
            cell_go        <= in_range;
          end else begin
            group_sum      <= gs_new;
            pixel_in_group <= pixel_in_group + 3'd1;
            cell_go        <= 1'b0;
          end
        end
        rbdr_pkg::S_UPD: begin
          run_length <= rl_next;
          run_level  <= rv_next;
          cell_go    <= 1'b0;
          if (cell_go) begin
            cell_index <= cell_index + rbdr_pkg::CIDX_W'(1);
          end
          if (eol) begin
            line_in_group  <= last_line ? 3'd0 : line_in_group + 3'd1;
            cell_index     <= '0;
            pixel_in_group <= 3'd0;
            group_sum      <= 7'd0;
          end
        end
        default: ;
      endcase
    end
  end

  rbdr_encoder u_enc (
    .clk       (clk),
    .rst       (rst),
    .start     (enc_start),
    .req       (req),
    .code_byte (run_code_byte),
    .out_stall (out_stall),
    .busy      (enc_busy),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  `RBDR_NEVER(a_mem_rw_overlap, clk, rst, mem_we && mem_re, "cell store read and write overlap")
  `RBDR_ASSERT(a_accept_seq, clk, rst, accept |=> (state == rbdr_pkg::S_SUM),
               "accepted pixel did not start the sequence")
  `RBDR_NEVER(a_accept_enc_busy, clk, rst, accept && enc_busy, "pixel taken while coder busy")

endmodule

`default_nettype wire

// ----- tb/rgb_block_downscale_rle_top_tb.sv -----
`default_nettype none

module rgb_block_downscale_rle_top_tb;

  localparam int RANDOM_ITEMS = 160;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [7:0] RUN_OF_ONE = rbdr_pkg::ASCII_SPACE + 8'd1;

  typedef enum logic { ROW_PIXEL, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [rbdr_pkg::CFG_IW-1:0] idx;
    logic [7:0]                  data;
    logic [7:0]                  r, g, b;
    logic                        eol;
    logic                        typed;
    int                          n;
    logic [55:0]                 want;   // typed bytes, first one in the top byte
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } coded_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red = '0, green = '0, blue = '0;
  logic line_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic last_byte;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rbdr_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  rgb_block_downscale_rle_top uut (
    .clk, .rst, .in_valid, .in_stall, .red, .green, .blue, .line_end,
    .out_valid, .out_stall, .out_byte, .last_byte,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // encoder image: registers, counters, open run and the line store
  logic [3:0] scale_reg = rbdr_pkg::SCALE_RESET;
  logic [7:0] code_reg  = 8'd0;
  logic [2:0] line_grp  = '0;
  logic [2:0] pix_grp   = '0;
  logic [6:0] grp_sum   = '0;
  logic [8:0] cell_idx  = '0;
  logic [3:0] run_lev   = '0;
  logic [6:0] run_len   = '0;
  logic [6:0] cell_store [rbdr_pkg::CELLS];
  logic       cell_written [rbdr_pkg::CELLS];

  coded_word_t pixel_words [$];
  coded_word_t coded_q [$];
  stim_row_t   dir_rows [$];

  int errors = 0;
  int pixels_sent = 0;
  int stall_left = 0;
  logic calm_in = 1'b0;

  function automatic int eff_factor();
    if (scale_reg == 4'd0) return 1;
    if (scale_reg > rbdr_pkg::SCALE_MAX) return int'(rbdr_pkg::SCALE_MAX);
    return int'(scale_reg);
  endfunction

  function automatic void put_byte(input logic [7:0] v);
    pixel_words.push_back('{v, 1'b0});
  endfunction

  function automatic void flush_run();
    put_byte(code_reg);
    put_byte({1'b0, run_len} + rbdr_pkg::ASCII_SPACE);
    put_byte({4'd0, run_lev} + rbdr_pkg::ASCII_ZERO);
    run_len = '0;
  endfunction

  function automatic void code_level(input logic [3:0] lev);
    if (run_len != 0 && lev == run_lev) begin
      run_len++;
    end else begin
      if (run_len != 0) flush_run();
      run_lev = lev;
      run_len = 7'd1;
    end
    if (run_len >= rbdr_pkg::MAX_RUN) flush_run();
  endfunction

  // bytes one pixel produces, left in pixel_words
  function automatic void encode_pixel(input logic [7:0] r, g, b, input logic eol);
    int f, gray, h, sum, lev;
    logic last_line;
    pixel_words.delete();
    f = eff_factor();
    last_line = (line_grp + 1 >= f);
    gray = (rbdr_pkg::W_RED * r + rbdr_pkg::W_GREEN * g + rbdr_pkg::W_BLUE * b)
           / rbdr_pkg::GRAY_DIV;
    grp_sum = 7'(grp_sum + gray);
    if (pix_grp + 1 >= f) begin
      h = grp_sum / f;
      if (h > rbdr_pkg::MAX_LEVEL) h = rbdr_pkg::MAX_LEVEL;
      grp_sum = '0;
      pix_grp = '0;
      if (cell_idx < rbdr_pkg::CELLS) begin
        sum = (line_grp == 0) ? h : cell_store[cell_idx] + h;
        cell_store[cell_idx] = 7'(sum);
        cell_written[cell_idx] = 1'b1;
        if (last_line) begin
          lev = (sum & 8'h7F) / f;
          if (lev > rbdr_pkg::MAX_LEVEL) lev = rbdr_pkg::MAX_LEVEL;
          code_level(4'(lev));
        end
        cell_idx++;
      end
    end else begin
      pix_grp++;
    end
    if (eol) begin
      if (last_line) begin
        if (run_len != 0) flush_run();
        put_byte(rbdr_pkg::NEWLINE);
        line_grp = '0;
      end else begin
        line_grp++;
      end
      cell_idx = '0;
      pix_grp = '0;
      grp_sum = '0;
    end
    if (pixel_words.size() > 0) pixel_words[pixel_words.size() - 1].last = 1'b1;
  endfunction

  // a later line of a group must not reach a cell its store slot never got
  function automatic logic line_needs_close();
    int nxt;
    nxt = cell_idx;
    if (pix_grp + 1 >= eff_factor() && cell_idx < rbdr_pkg::CELLS) nxt++;
    return line_grp != 0 && nxt < rbdr_pkg::CELLS && !cell_written[nxt];
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm_in || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] pick_scale();
    int p;
    logic [3:0] s;
    p = $urandom_range(0, 19);
    if (p < 1) s = 4'd0;
    else if (p < 2) s = rbdr_pkg::SCALE_MAX;
    else if (p < 3) s = 4'($urandom_range(9, 15));
    else if (p < 10) s = 4'd1;
    else s = 4'($urandom_range(2, 4));
    return {4'($urandom), s};
  endfunction

  function automatic logic [7:0] pick_code();
    int p;
    p = $urandom_range(0, 3);
    if (p == 0) return 8'h00;
    if (p == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic void add_pix(input logic [7:0] r, g, b, input logic eol,
                                  input logic typed, input int n, input logic [55:0] want);
    dir_rows.push_back('{ROW_PIXEL, '0, '0, r, g, b, eol, typed, n, want});
  endfunction

  function automatic void add_reg(input logic [rbdr_pkg::CFG_IW-1:0] idx,
                                  input logic [7:0] data);
    dir_rows.push_back('{ROW_REG, idx, data, '0, '0, '0, 1'b0, 1'b0, 0, '0});
  endfunction

  task automatic send_pixel(input logic [7:0] r, g, b, input logic eol,
                            input logic typed, input int n, input logic [55:0] want);
    int gap;
    gap = pick_gap();
    if (!eol && line_needs_close()) eol = 1'b1;
    encode_pixel(r, g, b, eol);
    if (typed) begin
      for (int k = 0; k < n; k++) coded_q.push_back('{want[55 - 8 * k -: 8], k == n - 1});
    end else begin
      foreach (pixel_words[k]) coded_q.push_back(pixel_words[k]);
    end
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    line_end <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [rbdr_pkg::CFG_IW-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rbdr_pkg::REG_SCALE_FACTOR) scale_reg = data[3:0];
    else if (idx == rbdr_pkg::REG_RUN_CODE) code_reg = data;
  endtask

  // block idle: nothing owed, and any silent pixel has left the pipe
  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one line past the store width at factor 1: long runs and dropped cells
  task automatic overflow_line();
    logic [23:0] pix;
    settle();
    write_reg(rbdr_pkg::REG_SCALE_FACTOR, 8'd1);
    pix = 24'($urandom);
    if (line_grp != 0) send_pixel(pix[23:16], pix[15:8], pix[7:0], 1'b1, 1'b0, 0, '0);
    for (int k = 0; k < rbdr_pkg::CELLS + 20; k++) begin
      if (k >= 70 && $urandom_range(0, 5) == 0) pix = 24'($urandom);
      send_pixel(pix[23:16], pix[15:8], pix[7:0], k == rbdr_pkg::CELLS + 19,
                 1'b0, 0, '0);
    end
  endtask

  task automatic pixel_group();
    int f, cells, width, extra, total, ci;
    logic [23:0] pal [3];
    logic [23:0] pix;
    f = eff_factor();
    cells = (f >= 5) ? 1 : $urandom_range(1, 6);
    if (f <= 2 && $urandom_range(0, 9) == 0) cells = $urandom_range(20, 40);
    foreach (pal[i]) pal[i] = 24'($urandom);
    ci = 0;
    for (int l = 0; l < f; l++) begin
      if (l > 0 && $urandom_range(0, 11) == 0) begin
        settle();
        write_reg(rbdr_pkg::REG_SCALE_FACTOR, pick_scale());
      end
      calm_in = ($urandom_range(0, 3) == 0);
      width = cells;
      if (l > 0 && $urandom_range(0, 3) == 0) width = $urandom_range(0, cells);
      extra = (f > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, f - 1) : 0;
      total = width * f + extra;
      if (total == 0) total = 1;
      for (int p = 0; p < total; p++) begin
        if (p % f == 0 && $urandom_range(0, 3) == 0) ci = $urandom_range(0, 2);
        pix = ($urandom_range(0, 4) == 0) ? 24'($urandom) : pal[ci];
        send_pixel(pix[23:16], pix[15:8], pix[7:0], p == total - 1, 1'b0, 0, '0);
      end
    end
  endtask

  task automatic noise_lines();
    int n;
    logic [23:0] pix;
    n = $urandom_range(1, 12);
    calm_in = 1'b0;
    for (int p = 0; p < n; p++) begin
      if ($urandom_range(0, 24) == 0) begin
        settle();
        write_reg(rbdr_pkg::REG_SCALE_FACTOR, pick_scale());
      end
      pix = 24'($urandom);
      send_pixel(pix[23:16], pix[15:8], pix[7:0],
                 p == n - 1 || $urandom_range(0, 9) == 0, 1'b0, 0, '0);
    end
  endtask

  // receiver: short stalls mostly, some long ones, and quiet stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin : check_words
    coded_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (coded_q.size() == 0) begin
        $error("out_byte: expected no word, got %0d", out_byte);
        errors++;
      end else begin
        want = coded_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0d, got %0d", want.data, out_byte);
          errors++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte: expected %0b, got %0b", want.last, last_byte);
          errors++;
        end
      end
    end
  end

  initial begin
    logic prev_reg;
    int target;
    foreach (cell_written[i]) cell_written[i] = 1'b0;

    // factor 3 after reset: three lines of cells 9 then 0
    for (int ln = 0; ln < 3; ln++) begin
      for (int k = 0; k < 5; k++)
        add_pix(k < 3 ? 8'hFF : 8'h00, k < 3 ? 8'hFF : 8'h00, k < 3 ? 8'hFF : 8'h00,
                1'b0, 1'b1, 0, '0);
      if (ln < 2) add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 0, '0);
      else add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 7,
                   {8'h00, RUN_OF_ONE, rbdr_pkg::ASCII_ZERO + 8'd9,
                    8'h00, RUN_OF_ONE, rbdr_pkg::ASCII_ZERO, rbdr_pkg::NEWLINE});
    end
    add_reg(rbdr_pkg::REG_SCALE_FACTOR, 8'd1);
    add_reg(rbdr_pkg::REG_RUN_CODE, 8'hFF);
    add_reg(rbdr_pkg::CFG_IW'(2), 8'hAA);       // unused indexes are ignored
    add_reg(rbdr_pkg::CFG_IW'(3), 8'h55);
    add_pix(8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 0, '0);
    add_pix(8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 3,
            {8'hFF, RUN_OF_ONE, rbdr_pkg::ASCII_ZERO + 8'd3, 32'd0});
    add_pix(8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 7,
            {8'hFF, RUN_OF_ONE, rbdr_pkg::ASCII_ZERO + 8'd5,
             8'hFF, RUN_OF_ONE, rbdr_pkg::ASCII_ZERO, rbdr_pkg::NEWLINE});
    add_pix(8'h80, 8'h40, 8'hC8, 1'b0, 1'b0, 0, '0);
    // factor 0 behaves as 1; the open run of level 3 closes first
    add_reg(rbdr_pkg::REG_SCALE_FACTOR, 8'd0);
    add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 7,
            {8'hFF, RUN_OF_ONE, rbdr_pkg::ASCII_ZERO + 8'd3,
             8'hFF, RUN_OF_ONE, rbdr_pkg::ASCII_ZERO, rbdr_pkg::NEWLINE});
    // factor 15 behaves as 8; lone pixel is a dropped partial group
    add_reg(rbdr_pkg::REG_SCALE_FACTOR, 8'hFF);
    add_pix(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    prev_reg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!prev_reg) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        prev_reg = 1'b1;
      end else begin
        send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].eol,
                   dir_rows[i].typed, dir_rows[i].n, dir_rows[i].want);
        prev_reg = 1'b0;
      end
    end

    overflow_line();
    target = pixels_sent + RANDOM_ITEMS;
    while (pixels_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_reg(rbdr_pkg::REG_SCALE_FACTOR, pick_scale());
        write_reg(rbdr_pkg::REG_RUN_CODE, pick_code());
      end
      if ($urandom_range(0, 4) == 0) noise_lines();
      else pixel_group();
    end

    settle();
    if (errors == 0) begin
      $display("rgb_block_downscale_rle_top verification clean");
    end else begin
      $display("rgb_block_downscale_rle_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rgb_block_downscale_rle_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/rbdr_pkg.sv
src/rbdr_cell_ram.sv
src/rbdr_encoder.sv
src/rgb_block_downscale_rle_top.sv
tb/rgb_block_downscale_rle_top_tb.sv
